### hw/rtl/length_prefixed_frame_deframer_top_defines.svh
// Assertion macros for the length-prefixed frame deframer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPFD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LPFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lpfd_pkg.sv
// Package for the length-prefixed frame deframer: field widths, header
// layout, result and error codes, register indexes, phase type. No dependencies.
`default_nettype none

package lpfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CNT_W     = 4;

    // header layout
    localparam logic [CNT_W-1:0] HDR_LAST = 4'd9;
    localparam logic [CNT_W-1:0] LEN_AT   = 4'd2;
    localparam logic [CNT_W-1:0] LEN_END  = 4'd5;
    localparam logic [CNT_W-1:0] SID_AT   = 4'd6;
    localparam logic [CNT_W-1:0] TYPE_AT  = 4'd1;
    localparam logic [CNT_W-1:0] VER_AT   = 4'd0;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    localparam logic ERR_VERSION = 1'b0;
    localparam logic ERR_LENGTH  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 2'd1;

    localparam logic [BYTE_W-1:0] VERSION_RESET     = 8'd1;
    localparam logic [WORD_W-1:0] MAX_PAYLOAD_RESET = 32'd1048576;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_ERROR   = 3'b100
    } phase_t;

endpackage

`default_nettype wire

### hw/rtl/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer: header parse, checks, payload pass-through.
// Depends on lpfd_pkg and length_prefixed_frame_deframer_top_defines.svh.
//
//   channel | direction | transaction
//   s_      | in        | one raw stream byte
//   m_      | out       | one result (payload byte, empty frame or error)
//   cfg_    | in        | one register write (index, data)
//
// One byte per cycle while s_ready is high: each result passes through next-state
// logic straight into the result register; the result register sets the latency.
// s_ready drops only while a result is held by m_ready low.
// Reset clears phase, counters, length, error, m_valid; cfg_ready is always high.
// After an error every byte yields an error result until reset.
`default_nettype none

`include "length_prefixed_frame_deframer_top_defines.svh"

module length_prefixed_frame_deframer_top
    import lpfd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_in_byte,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [KIND_W-1:0]         m_kind,
    output logic                      m_error_code,
    output logic [BYTE_W-1:0]         m_out_byte,
    output logic [BYTE_W-1:0]         m_frame_type,
    output logic [WORD_W-1:0]         m_flow_id,
    output logic [WORD_W-1:0]         m_frame_length,
    output logic                      m_last,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    phase_t              phase_reg, phase_next;
    logic                err_code_reg, err_code_next;
    logic [CNT_W-1:0]    hdr_count_reg, hdr_count_next;
    logic [BYTE_W-1:0]   version_reg, version_next;
    logic [BYTE_W-1:0]   type_reg, type_next;
    logic [WORD_W-1:0]   len_reg, len_next;
    logic [WORD_W-1:0]   sid_reg, sid_next;
    logic [WORD_W-1:0]   remain_reg, remain_next;
    logic [BYTE_W-1:0]   exp_version_reg;
    logic [WORD_W-1:0]   max_payload_reg;

    logic                m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]   m_kind_reg, m_kind_next;
    logic                m_error_code_reg, m_error_code_next;
    logic [BYTE_W-1:0]   m_out_byte_reg, m_out_byte_next;
    logic [BYTE_W-1:0]   m_frame_type_reg, m_frame_type_next;
    logic [WORD_W-1:0]   m_flow_id_reg, m_flow_id_next;
    logic [WORD_W-1:0]   m_frame_length_reg, m_frame_length_next;
    logic                m_last_reg, m_last_next;

    logic                s_fire;
    logic                emit;
    logic [WORD_W-1:0]   sid_full;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign sid_full  = {sid_reg[WORD_W-BYTE_W-1:0], s_in_byte};

    always_comb begin
        phase_next          = phase_reg;
        err_code_next       = err_code_reg;
        hdr_count_next      = hdr_count_reg;
        version_next        = version_reg;
        type_next           = type_reg;
        len_next            = len_reg;
        sid_next            = sid_reg;
        remain_next         = remain_reg;
        emit                = 1'b0;
        m_kind_next         = KIND_ERROR;
        m_error_code_next   = 1'b0;
        m_out_byte_next     = '0;
        m_frame_type_next   = '0;
        m_flow_id_next      = '0;
        m_frame_length_next = '0;
        m_last_next         = 1'b0;

        if (s_fire) begin
            case (phase_reg)
                PH_HEADER: begin
                    hdr_count_next = hdr_count_reg + 4'd1;
                    if (hdr_count_reg == VER_AT) begin
                        version_next = s_in_byte;
                    end
                    if (hdr_count_reg == TYPE_AT) begin
                        type_next = s_in_byte;
                    end
                    if (hdr_count_reg inside {[LEN_AT:LEN_END]}) begin
                        len_next = {len_reg[WORD_W-BYTE_W-1:0], s_in_byte};
                    end
                    if (hdr_count_reg >= SID_AT) begin
                        sid_next = sid_full;
                    end
                    if (hdr_count_reg == HDR_LAST) begin
                        hdr_count_next = '0;
                        remain_next    = len_reg;
                        if (version_reg != exp_version_reg) begin
                            phase_next        = PH_ERROR;
                            err_code_next     = ERR_VERSION;
                            emit              = 1'b1;
                            m_error_code_next = ERR_VERSION;
                        end else if (len_reg > max_payload_reg) begin
                            phase_next        = PH_ERROR;
                            err_code_next     = ERR_LENGTH;
                            emit              = 1'b1;
                            m_error_code_next = ERR_LENGTH;
                        end else if (len_reg == '0) begin
                            emit              = 1'b1;
                            m_kind_next       = KIND_EMPTY;
                            m_frame_type_next = type_reg;
                            m_flow_id_next    = sid_full;
                            m_last_next       = 1'b1;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    emit                = 1'b1;
                    remain_next         = remain_reg - 32'd1;
                    m_kind_next         = KIND_PAYLOAD;
                    m_out_byte_next     = s_in_byte;
                    m_frame_type_next   = type_reg;
                    m_flow_id_next      = sid_reg;
                    m_frame_length_next = len_reg;
                    m_last_next         = (remain_reg == 32'd1);
                    if (remain_reg == 32'd1) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_ERROR: begin
                    emit              = 1'b1;
                    m_error_code_next = err_code_reg;
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end

        m_valid_next = emit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            err_code_reg    <= ERR_VERSION;
            hdr_count_reg   <= '0;
            len_reg         <= '0;
            remain_reg      <= '0;
            m_valid_reg     <= 1'b0;
            exp_version_reg <= VERSION_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else begin
            phase_reg     <= phase_next;
            err_code_reg  <= err_code_next;
            hdr_count_reg <= hdr_count_next;
            len_reg       <= len_next;
            remain_reg    <= remain_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_index == CFG_EXPECTED_VERSION) begin
                exp_version_reg <= cfg_data[BYTE_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_MAX_PAYLOAD) begin
                max_payload_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        version_reg <= version_next;
        type_reg    <= type_next;
        sid_reg     <= sid_next;
        if (emit) begin
            m_kind_reg         <= m_kind_next;
            m_error_code_reg   <= m_error_code_next;
            m_out_byte_reg     <= m_out_byte_next;
            m_frame_type_reg   <= m_frame_type_next;
            m_flow_id_reg      <= m_flow_id_next;
            m_frame_length_reg <= m_frame_length_next;
            m_last_reg         <= m_last_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_error_code   = m_error_code_reg;
    assign m_out_byte     = m_out_byte_reg;
    assign m_frame_type   = m_frame_type_reg;
    assign m_flow_id      = m_flow_id_reg;
    assign m_frame_length = m_frame_length_reg;
    assign m_last         = m_last_reg;

    `LPFD_ASSERT_NEXT(a_err_byte_gives_err, aclk, aresetn,
        s_fire && phase_reg == PH_ERROR,
        m_valid_reg && m_kind_reg == KIND_ERROR && m_error_code_reg == $past(err_code_reg),
        "byte after latched error did not give an error result")
    `LPFD_ASSERT_NOW(a_err_result_latched, aclk, aresetn,
        m_valid_reg && m_kind_reg == KIND_ERROR,
        phase_reg == PH_ERROR,
        "error result without latched error")
    `LPFD_ASSERT_NOW(a_last_ends_payload, aclk, aresetn,
        m_valid_reg && m_last_reg && m_kind_reg == KIND_PAYLOAD,
        phase_reg == PH_HEADER,
        "still in payload after last byte")
    `LPFD_ASSERT_NOW(a_payload_remaining, aclk, aresetn,
        phase_reg == PH_PAYLOAD,
        remain_reg != '0,
        "payload phase with no bytes remaining")

endmodule

`default_nettype wire
